// ----- src/framed_pong_reply_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Framed pong reply parser assertion macros
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PONG_REPLY_PARSER_ASSERT_SVH
`define FRAMED_PONG_REPLY_PARSER_ASSERT_SVH

// condition holds at every edge outside reset
`define FPR_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FPR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants of the framed pong reply parser.
// ----------------------------------------------------------------------------
package fpr_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [31:0] pong_sequence;
      logic [31:0] pong_total;
      logic [31:0] invalid_total;
   } rsp_payload_type;

   localparam logic [1:0] EVENT_NONE     = 2'd0;
   localparam logic [1:0] EVENT_PONG     = 2'd1;
   localparam logic [1:0] EVENT_BAD      = 2'd2;
   localparam logic [1:0] EVENT_OVERFLOW = 2'd3;

   localparam logic [5:0] CAPACITY_RESET = 6'd47;
   localparam logic [5:0] PREFIX_LEN     = 6'd5;

   localparam logic [7:0] CHAR_OPEN  = 8'h3C;
   localparam logic [7:0] CHAR_CLOSE = 8'h3E;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [7:0] PREFIX_TEXT [5] = '{8'h50, 8'h4F, 8'h4E, 8'h47, 8'h2C};

   // number parser phases
   localparam logic [1:0] PHASE_SPACE  = 2'd0;
   localparam logic [1:0] PHASE_SIGN   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;

endpackage

// ----- src/fpr_stream_if.sv -----
// ----------------------------------------------------------------------------
// fpr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface fpr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/framed_pong_reply_parser.sv -----
// ----------------------------------------------------------------------------
// Framed pong reply parser
// Parses '<'...'>' framed replies and reports pong sequence numbers.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while the result side keeps up, and
// each byte gives one result item. A byte is held in the input register, then
// the frame and number state and the counters update together (prefix compare,
// a times-ten multiply by shift and add with overflow check, a 32-bit negate
// on close), and the result lands in a two-entry output register; the sustained
// rate is one item per cycle while the result side keeps up.
// The frame state update is the loop that sets that rate. No clearing pass is
// needed after reset. The payload capacity register may only be written
// while no item is in flight.
`include "framed_pong_reply_parser_assert.svh"

module framed_pong_reply_parser
   import fpr_pkg::*;
#(
   parameter int FRAME_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   fpr_stream_if.sink   req_chan,
   fpr_stream_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);

   localparam logic [5:0] CAP_MAX = 6'(FRAME_BYTES - 1);

   logic [5:0]  capacity_ff;
   logic [7:0]  in_byte_ff;
   logic        in_valid_ff;

   logic        in_frame_ff, in_frame_in;
   logic [5:0]  length_ff, length_in;
   logic        prefix_ok_ff, prefix_ok_in;
   logic [1:0]  phase_ff, phase_in;
   logic        negative_ff, negative_in;
   logic        saturated_ff, saturated_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] sequence_ff, sequence_in;
   logic [31:0] pong_cnt_ff, pong_cnt_in;
   logic [31:0] invalid_cnt_ff, invalid_cnt_in;
   logic [1:0]  event_in;

   rsp_payload_type out_data_ff, skid_data_ff, result;
   logic            out_valid_ff, skid_valid_ff;

   logic        advance, pop;
   logic [5:0]  cap;
   logic [7:0]  b;
   logic        is_digit, is_space;
   logic [35:0] acc_next;

   assign advance = in_valid_ff && !skid_valid_ff;
   assign pop     = out_valid_ff && rsp_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   assign cap      = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign b        = in_byte_ff;
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign is_space = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) ||
                     (b == CHAR_FF);
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                     {32'd0, b[3:0]};

   always_comb begin
      in_frame_in    = in_frame_ff;
      length_in      = length_ff;
      prefix_ok_in   = prefix_ok_ff;
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      saturated_in   = saturated_ff;
      acc_in         = acc_ff;
      sequence_in    = sequence_ff;
      pong_cnt_in    = pong_cnt_ff;
      invalid_cnt_in = invalid_cnt_ff;
      event_in       = EVENT_NONE;

      if (b == CHAR_OPEN) begin
         in_frame_in  = 1'b1;
         length_in    = '0;
         prefix_ok_in = 1'b1;
         phase_in     = PHASE_SPACE;
         negative_in  = 1'b0;
         saturated_in = 1'b0;
         acc_in       = '0;
      end else if (!in_frame_ff) begin
         // drop bytes outside a frame
      end else if (b == CHAR_CLOSE) begin
         in_frame_in = 1'b0;
         length_in   = '0;
         if (prefix_ok_ff && (length_ff >= PREFIX_LEN)) begin
            if (saturated_ff) begin
               sequence_in = '1;
            end else if (negative_ff) begin
               sequence_in = 32'd0 - acc_ff;
            end else begin
               sequence_in = acc_ff;
            end
            pong_cnt_in = pong_cnt_ff + 32'd1;
            event_in    = EVENT_PONG;
         end else begin
            invalid_cnt_in = invalid_cnt_ff + 32'd1;
            event_in       = EVENT_BAD;
         end
      end else if ((b == CHAR_CR) || (b == CHAR_LF)) begin
         // skip line endings inside a frame
      end else if (length_ff < cap) begin
         length_in = length_ff + 6'd1;
         if (length_ff < PREFIX_LEN) begin
            if (b != PREFIX_TEXT[length_ff[2:0]]) begin
               prefix_ok_in = 1'b0;
            end
         end else begin
            case (phase_ff)
               PHASE_SPACE, PHASE_SIGN, PHASE_DIGITS: begin
                  if (is_digit) begin
                     phase_in = PHASE_DIGITS;
                     if (!saturated_ff) begin
                        if (acc_next[35:32] != 4'd0) begin
                           saturated_in = 1'b1;
                        end else begin
                           acc_in = acc_next[31:0];
                        end
                     end
                  end else if (phase_ff != PHASE_SPACE) begin
                     phase_in = PHASE_DONE;
                  end else if (is_space) begin
                     // hold in leading space
                  end else if (b == CHAR_PLUS) begin
                     phase_in = PHASE_SIGN;
                  end else if (b == CHAR_MINUS) begin
                     negative_in = 1'b1;
                     phase_in    = PHASE_SIGN;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               default: begin
                  // ignore everything after the number
               end
            endcase
         end
      end else begin
         in_frame_in    = 1'b0;
         length_in      = '0;
         invalid_cnt_in = invalid_cnt_ff + 32'd1;
         event_in       = EVENT_OVERFLOW;
      end

      result.event_res     = event_in;
      result.pong_sequence = sequence_in;
      result.pong_total    = pong_cnt_in;
      result.invalid_total = invalid_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RESET;
         in_valid_ff    <= 1'b0;
         in_frame_ff    <= 1'b0;
         length_ff      <= '0;
         prefix_ok_ff   <= 1'b1;
         phase_ff       <= PHASE_SPACE;
         negative_ff    <= 1'b0;
         saturated_ff   <= 1'b0;
         acc_ff         <= '0;
         sequence_ff    <= '0;
         pong_cnt_ff    <= '0;
         invalid_cnt_ff <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end

         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            in_frame_ff    <= in_frame_in;
            length_ff      <= length_in;
            prefix_ok_ff   <= prefix_ok_in;
            phase_ff       <= phase_in;
            negative_ff    <= negative_in;
            saturated_ff   <= saturated_in;
            acc_ff         <= acc_in;
            sequence_ff    <= sequence_in;
            pong_cnt_ff    <= pong_cnt_in;
            invalid_cnt_ff <= invalid_cnt_in;
         end

         // advance never coincides with a full skid stage
         if (pop) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= advance;
            end
         end else if (advance) begin
            if (out_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.payload.rx_byte;
      end
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else begin
            out_data_ff <= result;
         end
      end else if (advance) begin
         if (out_valid_ff) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   `FPR_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff,
      "skid stage holds an item while the output register is empty")
   `FPR_ASSERT_ALWAYS(a_length_bound, length_ff <= CAP_MAX,
      "payload length beyond frame capacity")
   `FPR_ASSERT_ALWAYS(a_idle_length, in_frame_ff || (length_ff == 6'd0),
      "payload length nonzero outside a frame")
   `FPR_ASSERT_NEXT(a_pong_count, advance && (event_in == EVENT_PONG),
      pong_cnt_ff == $past(pong_cnt_ff) + 32'd1, "pong count did not advance")

endmodule

// ----- tb/framed_pong_reply_parser_test.sv -----
// ----------------------------------------------------------------------------
// Framed pong reply parser testbench
// Sends received bytes through the request channel and checks every reply item
// against a behavioral parser model in this module or a typed-in table reply.
// A short table of hand-written bytes comes first. Random frames follow: mostly
// well-formed pong replies with random numbers, mixed with broken frames and
// noise. Payload capacity changes between phases. Both channels idle at random.
// ----------------------------------------------------------------------------
module framed_pong_reply_parser_test
   import fpr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD  = 4;
   localparam int          RESET_CYCLES  = 10;
   localparam int          FRAME_BYTES   = 48;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          HOLD_CYCLES   = 150;
   localparam int unsigned RUN_LIMIT     = 200000;
   localparam int          IDLE_PERCENT  = 38;
   localparam int          PHASES        = 8;
   localparam int          HOLD_PHASE    = 1;
   localparam int          STEADY_PHASE  = 3;
   localparam int          RANDOM_PHASE  = 6;
   localparam logic [5:0]  CAPACITY_CEIL = 6'(FRAME_BYTES - 1);

   localparam logic [5:0] PHASE_CAPACITY [PHASES] =
      '{CAPACITY_RESET, 6'd63, 6'd0, 6'd5, 6'd6, 6'd1, 6'd0, CAPACITY_RESET};
   localparam int PHASE_ITEMS [PHASES] = '{70, 90, 40, 90, 60, 40, 90, 120};

   typedef struct packed {
      logic [7:0]      rx_byte;
      logic            typed;
      rsp_payload_type want;
   } plan_row_t;

   typedef struct packed {
      logic        in_frame;
      logic [5:0]  length;
      logic        prefix_ok;
      logic [1:0]  phase;
      logic        negative;
      logic        saturated;
      logic [31:0] accum;
      logic [31:0] sequence_num;
      logic [31:0] pongs;
      logic [31:0] invalids;
   } parser_state_t;

   // typed-in replies only where the answer is plain
   localparam plan_row_t DIRECTED_ROWS [24] = '{
      '{8'hFF, 1'b1, '{EVENT_NONE, 32'd0, 32'd0, 32'd0}},
      '{CHAR_OPEN, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{CHAR_OPEN, 1'b0, '0},
      '{CHAR_CLOSE, 1'b1, '{EVENT_BAD, 32'd0, 32'd0, 32'd1}},
      '{CHAR_OPEN, 1'b0, '0},
      '{PREFIX_TEXT[0], 1'b0, '0},
      '{PREFIX_TEXT[1], 1'b0, '0},
      '{PREFIX_TEXT[2], 1'b0, '0},
      '{PREFIX_TEXT[3], 1'b0, '0},
      '{PREFIX_TEXT[4], 1'b0, '0},
      '{CHAR_CR, 1'b0, '0},
      '{CHAR_SPACE, 1'b0, '0},
      '{CHAR_MINUS, 1'b0, '0},
      '{CHAR_ZERO + 8'd7, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{CHAR_NINE, 1'b0, '0},
      '{CHAR_CLOSE, 1'b1, '{EVENT_PONG, 32'hFFFF_FFF9, 32'd1, 32'd1}},
      '{CHAR_OPEN, 1'b0, '0},
      '{PREFIX_TEXT[0], 1'b0, '0},
      '{CHAR_LF, 1'b0, '0},
      '{PREFIX_TEXT[1], 1'b0, '0},
      '{CHAR_CLOSE, 1'b1, '{EVENT_BAD, 32'hFFFF_FFF9, 32'd1, 32'd2}},
      '{CHAR_CLOSE, 1'b1, '{EVENT_NONE, 32'hFFFF_FFF9, 32'd1, 32'd2}}
   };

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [5:0]  csr_wdata;

   logic        hold_off = 1'b0;
   logic        steady = 1'b0;
   int unsigned phase_num = 0;
   int unsigned error_count = 0;
   int unsigned reply_count = 0;
   int unsigned cycle_count = 0;

   logic [5:0]      capacity;
   parser_state_t   parser;
   plan_row_t       stimulus [$];
   rsp_payload_type expected_replies [$];

   fpr_stream_if #(.payload_type(req_payload_type)) req_chan ();
   fpr_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   framed_pong_reply_parser #(
      .FRAME_BYTES(FRAME_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // advance the parser model by one byte and return the reply it gives
   function automatic rsp_payload_type next_reply(input logic [7:0] b);
      rsp_payload_type reply;
      logic [5:0]      limit;
      logic [63:0]     wide;
      logic            is_digit;
      limit = (capacity > CAPACITY_CEIL) ? CAPACITY_CEIL : capacity;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      reply.event_res = EVENT_NONE;
      if (b == CHAR_OPEN) begin
         parser.in_frame  = 1'b1;
         parser.length    = '0;
         parser.prefix_ok = 1'b1;
         parser.phase     = PHASE_SPACE;
         parser.negative  = 1'b0;
         parser.saturated = 1'b0;
         parser.accum     = '0;
      end else if (!parser.in_frame) begin
      end else if (b == CHAR_CLOSE) begin
         parser.in_frame = 1'b0;
         if (parser.prefix_ok && parser.length >= PREFIX_LEN) begin
            if (parser.saturated)
               parser.sequence_num = '1;
            else if (parser.negative)
               parser.sequence_num = 32'd0 - parser.accum;
            else
               parser.sequence_num = parser.accum;
            parser.pongs = parser.pongs + 32'd1;
            reply.event_res = EVENT_PONG;
         end else begin
            parser.invalids = parser.invalids + 32'd1;
            reply.event_res = EVENT_BAD;
         end
         parser.length = '0;
      end else if (b == CHAR_CR || b == CHAR_LF) begin
      end else if (parser.length < limit) begin
         if (parser.length < PREFIX_LEN) begin
            if (b != PREFIX_TEXT[parser.length[2:0]])
               parser.prefix_ok = 1'b0;
         end else if (parser.phase != PHASE_DONE) begin
            if (parser.phase == PHASE_SPACE && (b == CHAR_SPACE || b == CHAR_TAB ||
                                                b == CHAR_VT || b == CHAR_FF)) begin
            end else if (parser.phase == PHASE_SPACE &&
                         (b == CHAR_PLUS || b == CHAR_MINUS)) begin
               parser.negative = (b == CHAR_MINUS);
               parser.phase    = PHASE_SIGN;
            end else if (is_digit) begin
               parser.phase = PHASE_DIGITS;
               if (!parser.saturated) begin
                  wide = 64'(parser.accum) * 64'd10 + 64'(b - CHAR_ZERO);
                  if (wide > 64'hFFFF_FFFF)
                     parser.saturated = 1'b1;
                  else
                     parser.accum = wide[31:0];
               end
            end else begin
               parser.phase = PHASE_DONE;
            end
         end
         parser.length = parser.length + 6'd1;
      end else begin
         parser.in_frame = 1'b0;
         parser.length   = '0;
         parser.invalids = parser.invalids + 32'd1;
         reply.event_res = EVENT_OVERFLOW;
      end
      reply.pong_sequence = parser.sequence_num;
      reply.pong_total    = parser.pongs;
      reply.invalid_total = parser.invalids;
      return reply;
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      stimulus.push_back('{rx_byte: b, typed: 1'b0, want: '0});
      // stray line breaks, skipped inside a frame
      if ($urandom_range(99) < 5)
         stimulus.push_back('{rx_byte: ($urandom_range(1) ? CHAR_CR : CHAR_LF),
                              typed: 1'b0, want: '0});
   endfunction

   // mostly pong frames with random numbers; some broken frames and noise
   function automatic void queue_traffic(input int unsigned target);
      int unsigned start_size;
      int unsigned pick;
      logic [7:0]  text [$];
      string       digits;
      start_size = stimulus.size();
      while (stimulus.size() - start_size < target) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(255)));
         end else begin
            text = {};
            for (int k = 0; k < 5; k++) text.push_back(PREFIX_TEXT[k]);
            repeat ($urandom_range(0, 2)) begin
               case ($urandom_range(3))
                  0: text.push_back(CHAR_SPACE);
                  1: text.push_back(CHAR_TAB);
                  2: text.push_back(CHAR_VT);
                  default: text.push_back(CHAR_FF);
               endcase
            end
            case ($urandom_range(3))
               0: text.push_back(CHAR_PLUS);
               1: text.push_back(CHAR_MINUS);
               default: ;
            endcase
            case ($urandom_range(5))
               0: digits = "";
               1: digits = $sformatf("%0d", $urandom_range(999));
               2: digits = $sformatf("%0d", $urandom());
               3: digits = $urandom_range(1) ? "4294967295" : "4294967296";
               4: digits = $sformatf("%0d%0d", $urandom_range(1, 99), $urandom());
               default: digits = $sformatf("%0d", $urandom_range(99999));
            endcase
            for (int k = 0; k < digits.len(); k++) text.push_back(digits[k]);
            if ($urandom_range(99) < 25)
               text.push_back(8'($urandom_range(255)));
            if (pick < 30) begin
               case ($urandom_range(2))
                  0: text[$urandom_range(4)] = 8'($urandom_range(255));
                  1: text = text[0:$urandom_range(3)];
                  default: text.insert($urandom_range(text.size() - 1), CHAR_OPEN);
               endcase
            end
            queue_byte(CHAR_OPEN);
            foreach (text[k]) queue_byte(text[k]);
            if ($urandom_range(99) >= 3)
               queue_byte(CHAR_CLOSE);
         end
      end
   endfunction

   task automatic send_row(input plan_row_t row);
      rsp_payload_type reply;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= req_payload_type'(row.rx_byte);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      reply = next_reply(row.rx_byte);
      expected_replies.push_back(row.typed ? row.want : reply);
   endtask

   task automatic write_capacity(input logic [5:0] value);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      capacity = value;
   endtask

   task automatic report_mismatch(input string line);
      $display("[%0t] reply %0d: %s", $realtime, reply_count, line);
      error_count++;
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      capacity         = CAPACITY_RESET;
      parser           = '0;
      parser.prefix_ok = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0)
            write_capacity(p == RANDOM_PHASE ? 6'($urandom_range(2, 46))
                                             : PHASE_CAPACITY[p]);
         phase_num = p;
         steady <= (p == STEADY_PHASE);
         if (p == 0)
            foreach (DIRECTED_ROWS[i]) stimulus.push_back(DIRECTED_ROWS[i]);
         queue_traffic(PHASE_ITEMS[p]);
         while (stimulus.size() != 0) send_row(stimulus.pop_front());
         req_chan.valid <= 1'b0;
      end

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hold the reply side off long enough to back the block up
   initial begin
      wait (phase_num == HOLD_PHASE);
      repeat (25) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (hold_off)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected item, event_res %0d", got.event_res));
         end else begin
            want = expected_replies.pop_front();
            if (got.event_res !== want.event_res)
               report_mismatch($sformatf("event_res %0d, want %0d",
                                         got.event_res, want.event_res));
            if (got.pong_sequence !== want.pong_sequence)
               report_mismatch($sformatf("pong_sequence %h, want %h",
                                         got.pong_sequence, want.pong_sequence));
            if (got.pong_total !== want.pong_total)
               report_mismatch($sformatf("pong_total %0d, want %0d",
                                         got.pong_total, want.pong_total));
            if (got.invalid_total !== want.invalid_total)
               report_mismatch($sformatf("invalid_total %0d, want %0d",
                                         got.invalid_total, want.invalid_total));
         end
         reply_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, expected_replies.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ----- files.f -----
+incdir+src
src/fpr_pkg.sv
src/fpr_stream_if.sv
src/framed_pong_reply_parser.sv
tb/framed_pong_reply_parser_test.sv
